/* src/tpi_pkg.sv */
// Package for the three-plane intersection core: payload widths, datapath
// widths and the division stage record. No dependencies.
package tpi_pkg;

   localparam int NORM_W   = 16;              // Q1.14 normal component
   localparam int OFF_W    = 32;              // Q16.16 offset and result
   localparam int PROD_W   = 2 * NORM_W;      // normal by normal
   localparam int CROSS_W  = PROD_W + 1;      // cross product component
   localparam int DPROD_W  = NORM_W + CROSS_W;
   localparam int DEN_W    = DPROD_W + 2;     // triple product
   localparam int NPROD_W  = OFF_W + CROSS_W;
   localparam int NUM_W    = NPROD_W + 2;     // weighted offset sum
   localparam int FRAC_SH  = 14;              // rescale Q18.44 / Q3.42 to Q16.16
   localparam int REM_W    = NUM_W + FRAC_SH; // dividend magnitude
   localparam int QUO_W    = OFF_W;           // quotient bits produced
   localparam int TRIAL_W  = REM_W + 2;
   localparam int DIV_STEPS = QUO_W;
   localparam int LANES    = 3;
   localparam int CROSS_N  = 9;

   typedef logic signed [NORM_W-1:0]  norm_type;
   typedef logic signed [OFF_W-1:0]   off_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [CROSS_W-1:0] cross_type;
   typedef logic signed [DPROD_W-1:0] dprod_type;
   typedef logic signed [DEN_W-1:0]   den_type;
   typedef logic signed [NPROD_W-1:0] nprod_type;
   typedef logic signed [NUM_W-1:0]   num_type;

   typedef struct packed {
      logic [LANES-1:0][REM_W-1:0] rem;
      logic [LANES-1:0][QUO_W-1:0] quo;
      logic [LANES-1:0]            nneg;
      logic [LANES-1:0]            big;
      logic [DEN_W-1:0]            dv;
      logic                        dneg;
      logic                        zero;
   } div_stage_type;

endpackage

/* src/tpi_if.sv */
// Valid/ready channel interfaces for the plane triple (request) and the
// intersection point (response). Depends on tpi_pkg.
interface tpi_req_if import tpi_pkg::*; ();
   logic    valid;
   logic    ready;
   norm_type plane1_nx, plane1_ny, plane1_nz;
   off_type  plane1_off;
   norm_type plane2_nx, plane2_ny, plane2_nz;
   off_type  plane2_off;
   norm_type plane3_nx, plane3_ny, plane3_nz;
   off_type  plane3_off;

   modport source (output valid, plane1_nx, plane1_ny, plane1_nz, plane1_off,
                   plane2_nx, plane2_ny, plane2_nz, plane2_off,
                   plane3_nx, plane3_ny, plane3_nz, plane3_off, input ready);
   modport sink   (input valid, plane1_nx, plane1_ny, plane1_nz, plane1_off,
                   plane2_nx, plane2_ny, plane2_nz, plane2_off,
                   plane3_nx, plane3_ny, plane3_nz, plane3_off, output ready);
endinterface

interface tpi_rsp_if import tpi_pkg::*; ();
   logic    valid;
   logic    ready;
   off_type point_x, point_y, point_z;
   logic    found;
   logic    overflow;

   modport source (output valid, point_x, point_y, point_z, found, overflow,
                   input ready);
   modport sink   (input valid, point_x, point_y, point_z, found, overflow,
                   output ready);
endinterface

/* src/three_plane_intersection_core.sv */
// Three-plane intersection core: one beat in, one beat out, fully pipelined.
// Pipeline from request beat to response beat: 4 arithmetic stages,
// 1 magnitude stage, 1 range-check stage, 32 divider stages, 1 output stage.
// Throughput: one beat per cycle while no response is held; the 32-stage restoring divider sets depth.
// Reset: synchronous, active high; clears stage valid bits and response valid.
module three_plane_intersection_core import tpi_pkg::*; (
   input logic        clock,
   input logic        reset,
   tpi_req_if.sink    req_bus,
   tpi_rsp_if.source  rsp_bus
);

   localparam int STAGES = 5 + DIV_STEPS + 1;

   // Global advance: the whole pipe moves when the response register is free
   // or being drained. Frozen stages hold data and valid bits in place.
   logic adv;
   logic [STAGES-1:0] vld_ff, vld_in;
   logic rsp_valid_ff;

   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // Stage 1: the eighteen normal-by-normal products.
   // Index order of the nine cross components: u = n2 x n3, v = n3 x n1, w = n1 x n2.
   prod_type prod_a_ff [CROSS_N], prod_b_ff [CROSS_N];
   prod_type prod_a_in [CROSS_N], prod_b_in [CROSS_N];
   norm_type nrm1_ff [LANES], nrm1_in [LANES];
   off_type  off1_ff [LANES], off1_in [LANES];

   always_comb begin
      norm_type ax, ay, az, bx, by, bz, cx, cy, cz;
      ax = req_bus.plane1_nx; ay = req_bus.plane1_ny; az = req_bus.plane1_nz;
      bx = req_bus.plane2_nx; by = req_bus.plane2_ny; bz = req_bus.plane2_nz;
      cx = req_bus.plane3_nx; cy = req_bus.plane3_ny; cz = req_bus.plane3_nz;
      prod_a_in[0] = PROD_W'(by) * PROD_W'(cz); prod_b_in[0] = PROD_W'(bz) * PROD_W'(cy);
      prod_a_in[1] = PROD_W'(bz) * PROD_W'(cx); prod_b_in[1] = PROD_W'(bx) * PROD_W'(cz);
      prod_a_in[2] = PROD_W'(bx) * PROD_W'(cy); prod_b_in[2] = PROD_W'(by) * PROD_W'(cx);
      prod_a_in[3] = PROD_W'(cy) * PROD_W'(az); prod_b_in[3] = PROD_W'(cz) * PROD_W'(ay);
      prod_a_in[4] = PROD_W'(cz) * PROD_W'(ax); prod_b_in[4] = PROD_W'(cx) * PROD_W'(az);
      prod_a_in[5] = PROD_W'(cx) * PROD_W'(ay); prod_b_in[5] = PROD_W'(cy) * PROD_W'(ax);
      prod_a_in[6] = PROD_W'(ay) * PROD_W'(bz); prod_b_in[6] = PROD_W'(az) * PROD_W'(by);
      prod_a_in[7] = PROD_W'(az) * PROD_W'(bx); prod_b_in[7] = PROD_W'(ax) * PROD_W'(bz);
      prod_a_in[8] = PROD_W'(ax) * PROD_W'(by); prod_b_in[8] = PROD_W'(ay) * PROD_W'(bx);
      nrm1_in[0] = ax; nrm1_in[1] = ay; nrm1_in[2] = az;
      off1_in[0] = req_bus.plane1_off;
      off1_in[1] = req_bus.plane2_off;
      off1_in[2] = req_bus.plane3_off;
   end

   // Stage 2: cross product components, exact in 33 bits.
   cross_type cross_ff [CROSS_N], cross_in [CROSS_N];
   norm_type  nrm2_ff [LANES];
   off_type   off2_ff [LANES];

   always_comb begin
      for (int i = 0; i < CROSS_N; i++) begin
         cross_in[i] = CROSS_W'(prod_a_ff[i]) - CROSS_W'(prod_b_ff[i]);
      end
   end

   // Stage 3: products for the triple product and the weighted offset sums.
   dprod_type dprod_ff [LANES], dprod_in [LANES];
   nprod_type nprod_ff [LANES][LANES], nprod_in [LANES][LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         dprod_in[i] = DPROD_W'(nrm2_ff[i]) * DPROD_W'(cross_ff[i]);
         for (int p = 0; p < LANES; p++) begin
            // lane i is the coordinate, p the plane whose offset weights it
            nprod_in[i][p] = NPROD_W'(off2_ff[p]) * NPROD_W'(cross_ff[LANES * p + i]);
         end
      end
   end

   // Stage 4: exact sums.
   den_type den_ff, den_in;
   num_type num_ff [LANES], num_in [LANES];

   always_comb begin
      den_in = DEN_W'(dprod_ff[0]) + DEN_W'(dprod_ff[1]) + DEN_W'(dprod_ff[2]);
      for (int i = 0; i < LANES; i++) begin
         num_in[i] = NUM_W'(nprod_ff[i][0]) + NUM_W'(nprod_ff[i][1])
                   + NUM_W'(nprod_ff[i][2]);
      end
   end

   // Stage 5: magnitudes and signs; the dividend carries the 2^14 rescale.
   div_stage_type ent_ff, ent_in;

   always_comb begin
      logic [NUM_W-1:0] mag;
      ent_in      = '0;
      ent_in.dneg = den_ff[DEN_W-1];
      ent_in.dv   = den_ff[DEN_W-1] ? DEN_W'(-den_ff) : DEN_W'(den_ff);
      ent_in.zero = (den_ff == '0);
      for (int i = 0; i < LANES; i++) begin
         mag = num_ff[i][NUM_W-1] ? NUM_W'(-num_ff[i]) : NUM_W'(num_ff[i]);
         ent_in.nneg[i] = num_ff[i][NUM_W-1];
         ent_in.rem[i]  = {mag, FRAC_SH'(0)};
      end
   end

   // Stage 6 and on: range check, then one restoring quotient bit per stage.
   // A quotient of 2^32 or more saturates regardless, so only 32 bits are formed.
   div_stage_type div_ff [DIV_STEPS+1], div_in [DIV_STEPS+1];

   always_comb begin
      div_in[0] = ent_ff;
      for (int i = 0; i < LANES; i++) begin
         div_in[0].big[i] = TRIAL_W'(ent_ff.rem[i]) >= (TRIAL_W'(ent_ff.dv) << QUO_W);
      end
   end

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
      localparam int K = DIV_STEPS - 1 - s;
      always_comb begin
         logic [TRIAL_W-1:0] shifted;
         div_in[s+1] = div_ff[s];
         shifted     = TRIAL_W'(div_ff[s].dv) << K;
         for (int i = 0; i < LANES; i++) begin
            if (TRIAL_W'(div_ff[s].rem[i]) >= shifted) begin
               div_in[s+1].rem[i]    = REM_W'(TRIAL_W'(div_ff[s].rem[i]) - shifted);
               div_in[s+1].quo[i][K] = 1'b1;
            end
         end
      end
   end

   // Output stage: sign, saturate, and force zeros on a degenerate triple.
   off_type pt_in [LANES], pt_ff [LANES];
   logic    found_in, found_ff, ovf_in, ovf_ff;

   always_comb begin
      div_stage_type   d;
      logic            resneg, sat;
      logic [QUO_W:0]  lim, qv;
      d      = div_ff[DIV_STEPS];
      ovf_in = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         resneg = (d.nneg[i] == d.dneg) && (d.big[i] || d.quo[i] != '0);
         lim    = resneg ? (QUO_W+1)'(1) << (QUO_W-1)
                         : ((QUO_W+1)'(1) << (QUO_W-1)) - (QUO_W+1)'(1);
         sat    = d.big[i] || ((QUO_W+1)'(d.quo[i]) > lim);
         qv     = sat ? lim : (QUO_W+1)'(d.quo[i]);
         pt_in[i] = resneg ? OFF_W'(-qv) : OFF_W'(qv);
         if (sat) begin
            ovf_in = 1'b1;
         end
         if (d.zero) begin
            pt_in[i] = '0;
         end
      end
      if (d.zero) begin
         ovf_in = 1'b0;
      end
      found_in = !d.zero;
   end

   // Valid bits advance with the data.
   assign vld_in = {vld_ff[STAGES-2:0], req_bus.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[STAGES-1];
      end
   end

   // Payload registers: no reset, advance with the pipe.
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         nrm1_ff   <= nrm1_in;
         off1_ff   <= off1_in;
         cross_ff  <= cross_in;
         nrm2_ff   <= nrm1_ff;
         off2_ff   <= off1_ff;
         dprod_ff  <= dprod_in;
         nprod_ff  <= nprod_in;
         den_ff    <= den_in;
         num_ff    <= num_in;
         ent_ff    <= ent_in;
         for (int s = 0; s <= DIV_STEPS; s++) begin
            div_ff[s] <= div_in[s];
         end
         pt_ff     <= pt_in;
         found_ff  <= found_in;
         ovf_ff    <= ovf_in;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.point_x  = pt_ff[0];
   assign rsp_bus.point_y  = pt_ff[1];
   assign rsp_bus.point_z  = pt_ff[2];
   assign rsp_bus.found    = found_ff;
   assign rsp_bus.overflow = ovf_ff;

`ifndef SYNTHESIS
   // A degenerate triple gives an all-zero beat.
   a_zero_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !found_ff |-> pt_ff[0] == '0 && pt_ff[1] == '0 &&
                                    pt_ff[2] == '0 && !ovf_ff)
      else $error("degenerate triple produced nonzero beat");

   // Saturation only happens on a real intersection.
   a_ovf_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ovf_ff |-> found_ff)
      else $error("overflow without found");

   // A held response freezes the valid bit of the last divider stage.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff[STAGES-1]))
      else $error("pipeline moved during stall");
`endif

endmodule

/* tb/tpi_tb_if.sv */
// Testbench-side note: channel interfaces come from the RTL (tpi_if.sv).
// This file holds the plane-triple and point beat records shared by the bench.
// Depends on tpi_pkg.
package tpi_tb_pkg;
   import tpi_pkg::*;

   typedef struct packed {
      norm_type n1x, n1y, n1z;
      off_type  off1;
      norm_type n2x, n2y, n2z;
      off_type  off2;
      norm_type n3x, n3y, n3z;
      off_type  off3;
   } triple_type;

   typedef struct packed {
      off_type px, py, pz;
      logic    found;
      logic    overflow;
   } point_type;
endpackage

/* tb/three_plane_intersection_core_tb.sv */
// Testbench for three_plane_intersection_core: directed table then random
// plane triples, checked against an exact intersection predictor.
// Depends on tpi_pkg, tpi_tb_pkg and the RTL channel interfaces.
module three_plane_intersection_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tpi_pkg::*;
   import tpi_tb_pkg::*;

   localparam int LATENCY  = 39;
   localparam int WDOG_MAX = 5000;
   localparam int N_RANDOM = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tpi_req_if req_bus ();
   tpi_rsp_if rsp_bus ();

   three_plane_intersection_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Table row: the triple, and a typed-in expectation where obvious.
   typedef struct {
      triple_type t;
      bit         has_exp;
      point_type  exp;
   } row_type;

   point_type  pending_points[$];
   triple_type stim_q[$];
   int         fail_count = 0;
   int         idle_cycles = 0;
   bit         stim_done = 1'b0;

   // Solve one coordinate: q = -(N * 2^14) / D truncated, then saturated.
   function automatic off_type solve_coord(logic signed [127:0] num,
                                           logic signed [127:0] den,
                                           inout logic ovf);
      logic signed [127:0] q;
      logic [127:0] mag_n, mag_d, mq;
      logic neg;
      begin
         neg   = (num < 0) != (den < 0);
         mag_n = (num < 0) ? -num : num;
         mag_d = (den < 0) ? -den : den;
         mq    = (mag_n << 14) / mag_d;
         // Sign flips: P = -N/D, so negative when N and D share sign.
         neg = !neg && mq != 0;
         if (!neg && mq > 128'h7FFFFFFF) begin
            ovf = 1'b1;
            return 32'h7FFFFFFF;
         end
         if (neg && mq > 128'h80000000) begin
            ovf = 1'b1;
            return 32'h80000000;
         end
         q = neg ? -$signed(mq) : $signed(mq);
         return q[31:0];
      end
   endfunction

   // Predict the intersection point of one plane triple.
   function automatic point_type intersect_planes(triple_type t);
      logic signed [127:0] ax, ay, az, bx, by, bz, cx, cy, cz, d1, d2, d3;
      logic signed [127:0] ux, uy, uz, vx, vy, vz, wx, wy, wz, den;
      point_type p;
      logic ovf;
      begin
         ax = t.n1x; ay = t.n1y; az = t.n1z; d1 = t.off1;
         bx = t.n2x; by = t.n2y; bz = t.n2z; d2 = t.off2;
         cx = t.n3x; cy = t.n3y; cz = t.n3z; d3 = t.off3;
         ux = by*cz - bz*cy; uy = bz*cx - bx*cz; uz = bx*cy - by*cx;
         vx = cy*az - cz*ay; vy = cz*ax - cx*az; vz = cx*ay - cy*ax;
         wx = ay*bz - az*by; wy = az*bx - ax*bz; wz = ax*by - ay*bx;
         den = ax*ux + ay*uy + az*uz;
         p = '0;
         ovf = 1'b0;
         if (den != 0) begin
            p.px = solve_coord(d1*ux + d2*vx + d3*wx, den, ovf);
            p.py = solve_coord(d1*uy + d2*vy + d3*wy, den, ovf);
            p.pz = solve_coord(d1*uz + d2*vz + d3*wz, den, ovf);
            p.found = 1'b1;
            p.overflow = ovf;
         end
         return p;
      end
   endfunction

   function automatic triple_type make_triple(int a1, int b1, int c1, int o1,
                                              int a2, int b2, int c2, int o2,
                                              int a3, int b3, int c3, int o3);
      triple_type t;
      begin
         t.n1x = norm_type'(a1); t.n1y = norm_type'(b1); t.n1z = norm_type'(c1);
         t.off1 = off_type'(o1);
         t.n2x = norm_type'(a2); t.n2y = norm_type'(b2); t.n2z = norm_type'(c2);
         t.off2 = off_type'(o2);
         t.n3x = norm_type'(a3); t.n3y = norm_type'(b3); t.n3z = norm_type'(c3);
         t.off3 = off_type'(o3);
         return t;
      end
   endfunction

   // Random normal: mostly full range, sometimes tiny, zero or extreme.
   function automatic norm_type rand_norm();
      case ($urandom_range(0, 7))
         0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         1:       return $signed(16'($urandom_range(0, 6))) - 16'sd3;
         2:       return 16'sd0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic off_type rand_off();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         1:       return $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
         default: return 32'($urandom);
      endcase
   endfunction

   function automatic triple_type rand_triple();
      triple_type t;
      begin
         t.n1x = rand_norm(); t.n1y = rand_norm(); t.n1z = rand_norm();
         t.n2x = rand_norm(); t.n2y = rand_norm(); t.n2z = rand_norm();
         t.n3x = rand_norm(); t.n3y = rand_norm(); t.n3z = rand_norm();
         t.off1 = rand_off(); t.off2 = rand_off(); t.off3 = rand_off();
         // Now and then make plane 3 parallel to plane 1 (zero triple product).
         if ($urandom_range(0, 15) == 0) begin
            t.n3x = t.n1x; t.n3y = t.n1y; t.n3z = t.n1z;
         end
         return t;
      end
   endfunction

   // Sender: walk the queue in bursts with random gaps; drop valid between bursts.
   initial begin
      row_type    rows[$];
      row_type    r;
      triple_type t;
      int         burst;
      int         gap;
      localparam int ONE = 16384;

      req_bus.valid <= 1'b0;
      req_bus.plane1_nx <= '0; req_bus.plane1_ny <= '0; req_bus.plane1_nz <= '0;
      req_bus.plane1_off <= '0;
      req_bus.plane2_nx <= '0; req_bus.plane2_ny <= '0; req_bus.plane2_nz <= '0;
      req_bus.plane2_off <= '0;
      req_bus.plane3_nx <= '0; req_bus.plane3_ny <= '0; req_bus.plane3_nz <= '0;
      req_bus.plane3_off <= '0;

      // Directed rows. All-zero normals: no point.
      r.t = '0; r.has_exp = 1; r.exp = '0; rows.push_back(r);
      // Axis planes x=-1, y=-2, z=-3 offsets -> point (1,2,3).
      r.t = make_triple(ONE,0,0,-65536, 0,ONE,0,-131072, 0,0,ONE,-196608);
      r.has_exp = 1;
      r.exp = '{px:32'sd65536, py:32'sd131072, pz:32'sd196608, found:1'b1,
                overflow:1'b0};
      rows.push_back(r);
      // Parallel planes 1 and 2.
      r.t = make_triple(ONE,0,0,5, ONE,0,0,7, 0,0,ONE,9);
      r.exp = '0; rows.push_back(r);
      // Tiny normals, huge offsets: saturate high and low.
      r.t = make_triple(1,0,0,32'sh80000000, 0,1,0,32'sh7FFFFFFF, 0,0,1,0);
      r.exp = '{px:32'sh7FFFFFFF, py:32'sh80000000, pz:32'sd0, found:1'b1,
                overflow:1'b1};
      rows.push_back(r);
      // Predictor-checked rows, most with extreme normal components.
      r.has_exp = 0;
      r.t = make_triple(-32768,32767,0,32'sh7FFFFFFF, 32767,-32768,1,32'sh80000000,
                        1,1,-32768,1);
      rows.push_back(r);
      r.t = make_triple(-32768,0,0,-1, 0,-32768,0,1, 0,0,-32768,32'sh7FFFFFFF);
      rows.push_back(r);
      r.t = make_triple(32767,32767,32767,-1, -32768,32767,32767,32'sh80000000,
                        32767,-32768,32767,32'sh7FFFFFFF);
      rows.push_back(r);
      r.t = make_triple(-1,-1,-1,-1, 1,-1,0,0, -1,0,1,-1);
      rows.push_back(r);
      r.t = make_triple(3,5,7,12345, -2,9,4,-54321, 8,-6,1,777);
      rows.push_back(r);
      r.t = make_triple(32767,0,0,32'sh7FFFFFFF, 0,32767,0,32'sh80000000,
                        0,0,32767,-1);
      rows.push_back(r);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].has_exp &&
             rows[i].exp != intersect_planes(rows[i].t)) begin
            $error("table row %0d point exp %p got %p", i, rows[i].exp,
                   intersect_planes(rows[i].t));
            fail_count++;
         end
         stim_q.push_back(rows[i].t);
      end
      repeat (N_RANDOM) stim_q.push_back(rand_triple());

      while (stim_q.size() > 0) begin
         burst = $urandom_range(1, 40);
         gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         while (burst > 0 && stim_q.size() > 0) begin
            t = stim_q[0];
            @(posedge clock);
            // Advance only after the previous beat was taken.
            if (!req_bus.valid || req_bus.ready) begin
               if (req_bus.valid) begin
                  void'(stim_q.pop_front());
                  burst--;
                  t = stim_q.size() > 0 ? stim_q[0] : t;
               end
               if (burst > 0 && stim_q.size() > 0) begin
                  req_bus.valid      <= 1'b1;
                  req_bus.plane1_nx  <= t.n1x; req_bus.plane1_ny <= t.n1y;
                  req_bus.plane1_nz  <= t.n1z; req_bus.plane1_off <= t.off1;
                  req_bus.plane2_nx  <= t.n2x; req_bus.plane2_ny <= t.n2y;
                  req_bus.plane2_nz  <= t.n2z; req_bus.plane2_off <= t.off2;
                  req_bus.plane3_nx  <= t.n3x; req_bus.plane3_ny <= t.n3y;
                  req_bus.plane3_nz  <= t.n3z; req_bus.plane3_off <= t.off3;
               end else begin
                  req_bus.valid <= 1'b0;
               end
            end
         end
         // The last beat of the burst is taken and valid is dropping: idle for the gap.
         repeat (gap) @(posedge clock);
      end
      stim_done = 1'b1;
   end

   // Predict at each accepted request beat.
   always @(posedge clock) begin
      triple_type seen;
      if (!reset && req_bus.valid && req_bus.ready) begin
         seen.n1x  = req_bus.plane1_nx;  seen.n1y = req_bus.plane1_ny;
         seen.n1z  = req_bus.plane1_nz;  seen.off1 = req_bus.plane1_off;
         seen.n2x  = req_bus.plane2_nx;  seen.n2y = req_bus.plane2_ny;
         seen.n2z  = req_bus.plane2_nz;  seen.off2 = req_bus.plane2_off;
         seen.n3x  = req_bus.plane3_nx;  seen.n3y = req_bus.plane3_ny;
         seen.n3z  = req_bus.plane3_nz;  seen.off3 = req_bus.plane3_off;
         pending_points.push_back(intersect_planes(seen));
      end
   end

   // Receiver: stall on a rotating pattern with quiet stretches.
   initial begin
      int phase;
      rsp_bus.ready <= 1'b0;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if ((phase / 300) % 3 == 0)
            rsp_bus.ready <= 1'b1;
         else
            rsp_bus.ready <= ($urandom_range(0, 9) > 2);
      end
   end

   // Compare each response beat with the oldest prediction.
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_points.size() == 0) begin
            $error("response beat with no request outstanding");
            fail_count++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_bus.point_x !== want.px) begin
               $error("point_x exp %0d got %0d", want.px, rsp_bus.point_x);
               fail_count++;
            end
            if (rsp_bus.point_y !== want.py) begin
               $error("point_y exp %0d got %0d", want.py, rsp_bus.point_y);
               fail_count++;
            end
            if (rsp_bus.point_z !== want.pz) begin
               $error("point_z exp %0d got %0d", want.pz, rsp_bus.point_z);
               fail_count++;
            end
            if (rsp_bus.found !== want.found) begin
               $error("found exp %0b got %0b", want.found, rsp_bus.found);
               fail_count++;
            end
            if (rsp_bus.overflow !== want.overflow) begin
               $error("overflow exp %0b got %0b", want.overflow, rsp_bus.overflow);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: count cycles with no beat on either side.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // End of run: drain, then settle, then report.
   initial begin
      wait (stim_done);
      @(posedge clock);
      wait (pending_points.size() == 0 || idle_cycles >= WDOG_MAX);
      if (pending_points.size() == 0)
         repeat (LATENCY + 10) @(posedge clock);
      if (pending_points.size() != 0 || idle_cycles >= WDOG_MAX)
         fail_count++;
      if (fail_count == 0)
         $display("** three_plane_intersection_core: PASSED **");
      else
         $display("** three_plane_intersection_core: FAILED **");
      $finish;
   end

   // Hang guard while stimulus is still running.
   initial begin
      wait (idle_cycles >= WDOG_MAX && !stim_done);
      $display("** three_plane_intersection_core: FAILED **");
      $finish;
   end
endmodule

/* sim.f */
src/tpi_pkg.sv
src/tpi_if.sv
src/three_plane_intersection_core.sv
tb/tpi_tb_if.sv
tb/three_plane_intersection_core_tb.sv
